>>> hdl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit converter package
// Shared widths, beat types and the digit-to-character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  localparam int unsigned VALUE_W        = 63;
  localparam int unsigned RADIX_W        = 5;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned MAX_DIGITS_DEF = 64;
  localparam int unsigned RESULT_CAP     = 63;

  // The dividend is padded by one bit so that it splits evenly into chunks.
  localparam int unsigned DIVIDEND_W = VALUE_W + 1;
  localparam int unsigned STEP_BITS  = 8;
  localparam int unsigned DIV_CYCLES = DIVIDEND_W / STEP_BITS;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_UPPERA = CHAR_W'(65);
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } out_beat_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPERA + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rdc_stream_if.sv
// ----------------------------------------------------------------------------
// Radix digit converter stream interface
// Valid/ready channel carrying one beat of the given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/radix_digit_converter_core.sv
// ----------------------------------------------------------------------------
// Radix digit converter core
// Converts a 63-bit value into base-N ASCII digits, most significant first.
// ----------------------------------------------------------------------------
// Each digit is one pass of the shared divider (8 quotient bits a cycle over a
// 64-bit dividend); each emitted digit then passes from the store read through
// the FETCH and LOAD states to the output register, plus any wait on the output side.
// The block takes no new value until the last digit of an item has left.
// Reset: radix returns to 10 and the sequencer to idle; the digit store is
// not cleared, as every entry is written before it is read.
`default_nettype none

module radix_digit_converter_core #(
  parameter int unsigned MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rdc_pkg::RADIX_W-1:0] cfg_wdata_i,
  rdc_stream_if.sink                       in_i,
  rdc_stream_if.source                     out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CAP   = (MAX_DIGITS > rdc_pkg::RESULT_CAP) ?
                                  rdc_pkg::RESULT_CAP : MAX_DIGITS;
  localparam int unsigned STEP_W = $clog2(rdc_pkg::DIV_CYCLES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_LOAD,
    ST_HOLD
  } state_e;

  state_e                            state_q;
  logic [rdc_pkg::RADIX_W-1:0]       radix_q;
  logic [rdc_pkg::RADIX_W-1:0]       base_q;
  logic [rdc_pkg::RADIX_W-1:0]       base_d;
  logic [rdc_pkg::DIVIDEND_W-1:0]    quo_q;
  logic [rdc_pkg::DIVIDEND_W-1:0]    quo_d;
  logic [rdc_pkg::RADIX_W-1:0]       rem_q;
  logic [rdc_pkg::RADIX_W-1:0]       rem_d;
  logic [STEP_W-1:0]                 step_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic                              out_valid_q;
  rdc_pkg::out_beat_t                out_beat_q;

  logic [rdc_pkg::DIGIT_W-1:0]       store_mem [MAX_DIGITS];
  logic [rdc_pkg::DIGIT_W-1:0]       rd_digit_q;
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_addr;
  logic [IDX_W-1:0]                  rd_addr;
  logic                              step_last;
  logic [CNT_W-1:0]                  cnt_inc;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_beat_q;

  // Out-of-range register values fold onto the nearest legal base.
  always_comb begin
    if (radix_q < rdc_pkg::RADIX_MIN) begin
      base_d = rdc_pkg::RADIX_MIN;
    end else if (radix_q > rdc_pkg::RADIX_MAX) begin
      base_d = rdc_pkg::RADIX_MAX;
    end else begin
      base_d = radix_q;
    end
  end

  // Shared restoring divider: STEP_BITS quotient bits per cycle. The
  // partial remainder never reaches twice the base, so it stays 5 bits wide.
  always_comb begin
    logic [rdc_pkg::RADIX_W:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < rdc_pkg::STEP_BITS; i++) begin
      trial = {rem_d, quo_d[rdc_pkg::DIVIDEND_W-1]};
      quo_d = {quo_d[rdc_pkg::DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, base_q}) begin
        trial    = trial - {1'b0, base_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[rdc_pkg::RADIX_W-1:0];
    end
  end

  assign step_last = (step_q == STEP_W'(rdc_pkg::DIV_CYCLES - 1));
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign wr_en     = (state_q == ST_DIV) && step_last;
  assign wr_addr   = cnt_q[IDX_W-1:0];
  assign rd_addr   = IDX_W'(cnt_q - CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= rem_d[rdc_pkg::DIGIT_W-1:0];
    end
    rd_digit_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rdc_pkg::RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_beat_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            quo_q   <= {1'b0, in_i.data.value};
            rem_q   <= '0;
            base_q  <= base_d;
            step_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_q <= quo_d;
          if (step_last) begin
            // One digit complete: restart the divider on the quotient.
            rem_q  <= '0;
            step_q <= '0;
            cnt_q  <= cnt_inc;
            if ((quo_d == '0) || (cnt_inc == CNT_W'(CAP))) begin
              state_q <= ST_FETCH;
            end
          end else begin
            rem_q  <= rem_d;
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_FETCH: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          out_valid_q           <= 1'b1;
          out_beat_q.digit_char <= rdc_pkg::digit_to_char(rd_digit_q);
          out_beat_q.last       <= (cnt_q == CNT_W'(1));
          cnt_q                 <= cnt_q - CNT_W'(1);
          state_q               <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= (cnt_q == '0) ? ST_IDLE : ST_FETCH;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/radix_digit_converter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix digit converter core testbench
// Feeds values through the converter under several radix settings and idling
// patterns, predicts the digit characters of each value and checks every
// output beat against them in order.
// ----------------------------------------------------------------------------

module radix_digit_converter_core_test;

  localparam int unsigned VALUE_W = rdc_pkg::VALUE_W;
  localparam int unsigned RADIX_W = rdc_pkg::RADIX_W;
  localparam int unsigned DIGIT_W = rdc_pkg::DIGIT_W;
  localparam int unsigned CHAR_W  = rdc_pkg::CHAR_W;

  localparam int MAX_DIGITS      = rdc_pkg::MAX_DIGITS_DEF;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 33;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 1500;
  localparam int PRESSURE_PHASE  = 4;

  localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = {VALUE_W{1'b1}};

  // Digit scoreboard: predicts the characters of each accepted value and
  // checks the output beats against them, oldest first.
  class digit_scoreboard;
    rdc_pkg::out_beat_t pending_q[$];
    int unsigned        fault_count = 0;
    logic [RADIX_W-1:0] radix_reg   = rdc_pkg::RADIX_RESET;

    function void set_radix(input logic [RADIX_W-1:0] r);
      radix_reg = r;
    endfunction

    // Register values outside two to sixteen are clamped to the nearest end.
    function int unsigned effective_base();
      if (radix_reg < rdc_pkg::RADIX_MIN) begin
        return 2;
      end
      if (radix_reg > rdc_pkg::RADIX_MAX) begin
        return 16;
      end
      return int'(radix_reg);
    endfunction

    function void note_value(input logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] quot;
      logic [DIGIT_W-1:0] digit_buf [MAX_DIGITS];
      int                 n_digits;
      int                 cap;
      int unsigned        base;
      rdc_pkg::out_beat_t beat;
      base     = effective_base();
      cap      = (MAX_DIGITS > rdc_pkg::RESULT_CAP) ? rdc_pkg::RESULT_CAP : MAX_DIGITS;
      quot     = v;
      n_digits = 0;
      do begin
        digit_buf[n_digits] = DIGIT_W'(quot % base);
        n_digits++;
        quot = quot / base;
      end while (quot != '0 && n_digits < cap);
      // Digits were gathered least significant first; they leave the other way.
      for (int i = n_digits - 1; i >= 0; i--) begin
        if (digit_buf[i] < rdc_pkg::DIGIT_TEN) begin
          beat.digit_char = rdc_pkg::CHAR_ZERO + CHAR_W'(digit_buf[i]);
        end else begin
          beat.digit_char = rdc_pkg::CHAR_UPPERA + CHAR_W'(digit_buf[i]) -
                            CHAR_W'(rdc_pkg::DIGIT_TEN);
        end
        beat.last = (i == 0);
        pending_q.push_back(beat);
      end
    endfunction

    task report(input string what);
      fault_count++;
      $display("[%0t] digit check: %s", $time, what);
    endtask

    task check_digit(input rdc_pkg::out_beat_t got);
      rdc_pkg::out_beat_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("beat char %0d last %0d with nothing outstanding",
                         got.digit_char, got.last));
      end else begin
        want = pending_q.pop_front();
        if (got.digit_char !== want.digit_char) begin
          report($sformatf("digit_char got %0d, wanted %0d",
                           got.digit_char, want.digit_char));
        end
        if (got.last !== want.last) begin
          report($sformatf("last got %0d, wanted %0d", got.last, want.last));
        end
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [RADIX_W-1:0] cfg_wdata_i;

  rdc_stream_if #(.payload_t(rdc_pkg::in_beat_t))  in_if ();
  rdc_stream_if #(.payload_t(rdc_pkg::out_beat_t)) out_if ();

  digit_scoreboard digits_sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req     = 1'b0;

  radix_digit_converter_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("radix_digit_converter_core test failed");
    $finish;
  end

  // Offers one value and holds it until the block takes the beat.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data.value <= v;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    digits_sb.note_value(v);
  endtask

  task automatic drain_digits();
    while (digits_sb.pending_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain_digits();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    digits_sb.set_radix(r);
  endtask

  // Random bit lengths keep most values short; some are runs of ones or sit on
  // a power of the current base, where the digit count changes.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int unsigned        len;
    int unsigned        base;
    int unsigned        power;
    base = digits_sb.effective_base();
    len  = $urandom_range(0, VALUE_W);
    v    = VALUE_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 7))
      0: begin
        v = VALUE_ALL_ONES >> (VALUE_W - len);
      end
      1, 2: begin
        v     = VALUE_W'(1);
        power = $urandom_range(0, VALUE_W - 1);
        for (int k = 0; k < power; k++) begin
          if (v <= VALUE_ALL_ONES / base) begin
            v = v * base;
          end
        end
        if ($urandom_range(0, 1) == 1) begin
          v = v - VALUE_W'(1);
        end
      end
      default: begin
        v &= VALUE_ALL_ONES >> (VALUE_W - len);
      end
    endcase
    return v;
  endfunction

  initial begin : digit_sink
    int unsigned hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        digits_sb.check_digit(out_if.data);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] directed_q[$];
    logic [RADIX_W-1:0] edge_radices[$];
    logic [RADIX_W-1:0] r;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Base ten straight out of reset: zero, single digits, digit-count steps
    // and the extremes of the value field.
    directed_q = '{
      63'd0, 63'd1, 63'd9, 63'd10, 63'd11, 63'd99, 63'd100,
      63'd999_999_999_999_999_999, 63'd1_000_000_000_000_000_000,
      VALUE_ALL_ONES, 63'h4000_0000_0000_0000,
      63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA
    };
    foreach (directed_q[i]) begin
      send_value(directed_q[i]);
    end
    in_if.valid <= 1'b0;

    // Out-of-range register values first, then both legal ends, then 1, 17, 3 and 7.
    edge_radices = '{5'd0, 5'd31, 5'd16, 5'd2, 5'd1, 5'd17, 5'd3, 5'd7};
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < edge_radices.size()) begin
        r = edge_radices[p];
      end else begin
        r = RADIX_W'($urandom_range(0, 31));
      end
      write_radix(r);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
      endcase
      if (p == PRESSURE_PHASE) begin
        hold_req = 1'b1;
      end
      send_value(VALUE_ALL_ONES);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_value(random_value());
      end
      in_if.valid <= 1'b0;
    end

    drain_digits();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (digits_sb.fault_count == 0) begin
      $display("radix_digit_converter_core test passed");
    end else begin
      $display("radix_digit_converter_core test failed");
    end
    $finish;
  end

endmodule
